@@ src/degree_coefficient_of_variation_macros.svh @@
// ----------------------------------------------------------------------------
// Degree coefficient of variation assertion macros
// Concurrent assertion shorthands clocked on clk_i, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DEGREE_COEFFICIENT_OF_VARIATION_MACROS_SVH
`define DEGREE_COEFFICIENT_OF_VARIATION_MACROS_SVH

// same-cycle implication
`define DCV_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DCV_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/dcv_pkg.sv @@
// ----------------------------------------------------------------------------
// Degree coefficient of variation package
// Shared widths, codes, state encoding and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package dcv_pkg;

  localparam int unsigned PointerWidthDefault = 32;
  localparam int unsigned FieldW    = 32;
  localparam int unsigned AccW      = 32;
  localparam int unsigned SqSumW    = 64;
  localparam int unsigned MulW      = 64;
  localparam int unsigned ProdW     = 96;
  localparam int unsigned FracShift = 32;
  localparam int unsigned RadW      = 128;
  localparam int unsigned RootW     = 64;
  localparam int unsigned RemW      = 68;
  localparam int unsigned DivRemW   = AccW + 1;
  localparam int unsigned CvW       = 32;
  localparam int unsigned RootSteps = RootW;
  localparam int unsigned StepW     = $clog2(RootSteps);

  typedef enum logic [1:0] {
    StatusOk         = 2'd0,
    StatusNoVertices = 2'd1,
    StatusZeroMean   = 2'd2,
    StatusBadOrder   = 2'd3
  } dcv_status_e;

  typedef enum logic [1:0] {
    MulQLo,
    MulQHi,
    MulSs
  } dcv_mul_e;

  typedef enum logic [3:0] {
    StAcc,
    StDrain1,
    StDrain2,
    StMulLo,
    StMulHi,
    StMulSs,
    StDiff,
    StSqrt,
    StDiv,
    StDone
  } dcv_state_e;

  typedef struct packed {
    logic     take;
    logic     clear;
    logic     mul_en;
    dcv_mul_e mul_sel;
    logic     load_root;
    logic     sqrt_step;
    logic     div_step;
    logic     out_load;
  } dcv_cmd_t;

  typedef struct packed {
    logic fail;
  } dcv_sts_t;

endpackage

`default_nettype wire

@@ src/dcv_dp.sv @@
// ----------------------------------------------------------------------------
// Degree coefficient of variation datapath
// Degree pipeline with accumulators, shared multiplier, bit-serial square root
// and divider, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dcv_dp import dcv_pkg::*; #(
  parameter int unsigned PointerWidth = PointerWidthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [FieldW-1:0] row_pointer_i,
  input  dcv_cmd_t          cmd_i,
  output dcv_sts_t          sts_o,
  output logic [CvW-1:0]    cv_q16_o,
  output logic [1:0]        status_o
);

  logic [PointerWidth-1:0]   ptr;
  logic                      descend;
  logic [PointerWidth-1:0]   prev_q;
  logic                      seen_q;
  logic                      bad_q;
  logic                      upd1_q, upd2_q;
  logic [PointerWidth-1:0]   d_q, d2_q;
  logic [2*PointerWidth-1:0] sq_q;
  logic [AccW-1:0]           count_q, sum_q;
  logic [SqSumW-1:0]         sumsq_q;
  dcv_status_e               status;

  logic [AccW-1:0]  mul_a, mul_b;
  logic [MulW-1:0]  mul_q, plo_q;
  logic [ProdW-1:0] a_q, v;

  logic [RadW-1:0]    rad_q;
  logic [RootW-1:0]   root_q;
  logic [RemW-1:0]    rem_q, rem_sh, trial;
  logic               sq_ge;
  logic [DivRemW-1:0] drem_q, dsh, dvs;
  logic               dv_ge;

  logic [CvW-1:0] cv_q;
  dcv_status_e    status_q;

  assign ptr     = row_pointer_i[PointerWidth-1:0];
  assign descend = ptr < prev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      seen_q  <= 1'b0;
      bad_q   <= 1'b0;
      upd1_q  <= 1'b0;
      upd2_q  <= 1'b0;
      count_q <= '0;
      sum_q   <= '0;
      sumsq_q <= '0;
    end else if (cmd_i.clear) begin
      prev_q  <= '0;
      seen_q  <= 1'b0;
      bad_q   <= 1'b0;
      upd1_q  <= 1'b0;
      upd2_q  <= 1'b0;
      count_q <= '0;
      sum_q   <= '0;
      sumsq_q <= '0;
    end else begin
      upd1_q <= cmd_i.take && seen_q && !descend && !bad_q;
      upd2_q <= upd1_q;
      if (cmd_i.take) begin
        prev_q <= ptr;
        seen_q <= 1'b1;
        if (seen_q && descend) begin
          bad_q <= 1'b1;
        end
      end
      if (upd2_q) begin
        if (count_q != '1) begin
          count_q <= count_q + AccW'(1);
        end
        sum_q   <= sum_q + AccW'(d2_q);
        sumsq_q <= sumsq_q + SqSumW'(sq_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    d_q  <= ptr - prev_q;
    d2_q <= d_q;
    sq_q <= (2*PointerWidth)'(d_q) * (2*PointerWidth)'(d_q);
  end

  always_comb begin
    if (bad_q) begin
      status = StatusBadOrder;
    end else if (count_q == '0) begin
      status = StatusNoVertices;
    end else if (sum_q == '0) begin
      status = StatusZeroMean;
    end else begin
      status = StatusOk;
    end
  end

  assign sts_o.fail = (status != StatusOk);

  always_comb begin
    case (cmd_i.mul_sel)
      MulQLo: begin
        mul_a = sumsq_q[AccW-1:0];
        mul_b = count_q;
      end
      MulQHi: begin
        mul_a = sumsq_q[SqSumW-1:AccW];
        mul_b = count_q;
      end
      MulSs: begin
        mul_a = sum_q;
        mul_b = sum_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign v      = a_q - ProdW'(mul_q);
  assign rem_sh = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign sq_ge  = rem_sh >= trial;
  assign dsh    = {drem_q[DivRemW-2:0], root_q[RootW-1]};
  assign dvs    = {1'b0, sum_q};
  assign dv_ge  = dsh >= dvs;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      mul_q <= MulW'(mul_a) * MulW'(mul_b);
      if (cmd_i.mul_sel == MulQHi) begin
        plo_q <= mul_q;
      end
      if (cmd_i.mul_sel == MulSs) begin
        a_q <= {mul_q, {FracShift{1'b0}}} + ProdW'(plo_q);
      end
    end
    if (cmd_i.load_root) begin
      rad_q  <= (a_q >= ProdW'(mul_q)) ? {v, {FracShift{1'b0}}} : '0;
      rem_q  <= '0;
      root_q <= '0;
      drem_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q  <= {rad_q[RadW-3:0], 2'b00};
      rem_q  <= sq_ge ? rem_sh - trial : rem_sh;
      root_q <= {root_q[RootW-2:0], sq_ge};
    end else if (cmd_i.div_step) begin
      drem_q <= dv_ge ? dsh - dvs : dsh;
      root_q <= {root_q[RootW-2:0], dv_ge};
    end
    if (cmd_i.out_load) begin
      status_q <= status;
      if (status != StatusOk) begin
        cv_q <= '0;
      end else if (root_q[RootW-1:CvW] != '0) begin
        cv_q <= '1;
      end else begin
        cv_q <= root_q[CvW-1:0];
      end
    end
  end

  assign cv_q16_o = cv_q;
  assign status_o = status_q;

endmodule

`default_nettype wire

@@ src/dcv_ctrl.sv @@
// ----------------------------------------------------------------------------
// Degree coefficient of variation controller
// Sequences accumulation, pipeline drain, final multiply, root, divide and
// result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module dcv_ctrl import dcv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     is_last_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dcv_cmd_t cmd_o,
  input  dcv_sts_t sts_i
);

  dcv_state_e       state_q, state_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             cnt_last;
  logic             out_free;

  assign cnt_last = (cnt_q == StepW'(RootSteps - 1));
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StAcc: begin
        if (in_valid_i && is_last_i) begin
          state_d = StDrain1;
        end
      end
      StDrain1: state_d = StDrain2;
      StDrain2: state_d = StMulLo;
      StMulLo:  state_d = sts_i.fail ? StDone : StMulHi;
      StMulHi:  state_d = StMulSs;
      StMulSs:  state_d = StDiff;
      StDiff:   state_d = StSqrt;
      StSqrt: begin
        if (cnt_last) begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (cnt_last) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StAcc;
        end
      end
      default: state_d = StAcc;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    cnt_d      = '0;
    unique case (state_q)
      StAcc: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      StMulLo: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MulQLo;
      end
      StMulHi: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MulQHi;
      end
      StMulSs: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MulSs;
      end
      StDiff: cmd_o.load_root = 1'b1;
      StSqrt: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d           = cnt_q + StepW'(1);
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + StepW'(1);
      end
      StDone: begin
        cmd_o.out_load = out_free;
        cmd_o.clear    = out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StAcc;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ src/degree_coefficient_of_variation.sv @@
// ----------------------------------------------------------------------------
// Degree coefficient of variation
// Row pointers are taken one per cycle while the graph streams in.
// After the item marked last: pipeline drain, final multiplies, 64-step root
// and 64-step divide, then the result load; an error status skips to the load.
// A result waits in the output register while the next graph streams in.
// Reset clears the accumulators, the controller and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module degree_coefficient_of_variation import dcv_pkg::*; #(
  parameter int unsigned POINTER_WIDTH = PointerWidthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FieldW-1:0] row_pointer_i,
  input  logic              is_last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CvW-1:0]    cv_q16_o,
  output logic [1:0]        status_o
);

  dcv_cmd_t cmd;
  dcv_sts_t sts;

  dcv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .is_last_i   (is_last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  dcv_dp #(
    .PointerWidth (POINTER_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .row_pointer_i (row_pointer_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cv_q16_o      (cv_q16_o),
    .status_o      (status_o)
  );

endmodule

`default_nettype wire

@@ src/dcv_checker.sv @@
// ----------------------------------------------------------------------------
// Degree coefficient of variation checker
// Port-level assertions on result handoff and busy behavior, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "degree_coefficient_of_variation_macros.svh"

module dcv_checker import dcv_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              is_last_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [CvW-1:0]    cv_q16_o,
  input logic [1:0]        status_o
);

  logic last_fire;

  assign last_fire = in_valid_i && in_ready_o && is_last_i;

  `DCV_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(cv_q16_o) && $stable(status_o), "result changed while stalled")
  `DCV_ASSERT_NOW(a_err_zero, out_valid_o && (status_o != StatusOk), cv_q16_o == '0, "nonzero value with error status")
  `DCV_ASSERT_NEXT(a_busy_after_last, last_fire, !in_ready_o, "item taken while finishing a graph")
  `DCV_ASSERT_NEXT(a_no_instant_result, last_fire, !$rose(out_valid_o), "result appeared without drain")

endmodule

bind degree_coefficient_of_variation dcv_checker u_dcv_checker (.*);

`default_nettype wire
